// File: rtl/tfcs_pkg.sv
package tfcs_pkg;

    localparam int FREQ_W     = 24;
    localparam int TEMP_W     = 18;
    localparam int RANGE_W    = FREQ_W + 1;
    localparam int PROD_W     = FREQ_W + TEMP_W;
    localparam int DEN_W      = TEMP_W + 4;
    localparam int REM_W      = DEN_W + 1;
    localparam int QUO_W      = PROD_W + 2;
    localparam int SUM_W      = QUO_W + 1;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int PC_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = FREQ_W'(800000);
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = FREQ_W'(3000000);
    localparam logic [TEMP_W-1:0] NORMAL_RST    = TEMP_W'(50000);
    localparam logic [TEMP_W-1:0] TOLERANCE_RST = TEMP_W'(70000);
    localparam logic [TEMP_W-1:0] CRITICAL_RST  = TEMP_W'(90000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_FREQ       = 3'd0,
        REG_MAX_FREQ       = 3'd1,
        REG_NORMAL_TEMP    = 3'd2,
        REG_TOLERANCE_TEMP = 3'd3,
        REG_CRITICAL_TEMP  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REGION_COOL = 2'd0,
        REGION_WARM = 2'd1,
        REGION_HOT  = 2'd2,
        REGION_HELD = 2'd3
    } region_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETUP,
        OP_MUL,
        OP_DIV,
        OP_FIX,
        OP_WRITE
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SKIP,
        COND_DIV_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ctrl_word_t;

    typedef struct packed {
        logic [FREQ_W-1:0] min_freq;
        logic [FREQ_W-1:0] max_freq;
        logic [TEMP_W-1:0] normal_temp;
        logic [TEMP_W-1:0] tolerance_temp;
        logic [TEMP_W-1:0] critical_temp;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div;
        logic fix;
        logic write;
    } dp_ctrl_t;

    typedef struct packed {
        logic skip;
        logic div_more;
    } dp_stat_t;

    localparam logic [PC_W-1:0] STEP_LOAD  = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_SETUP = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_MUL   = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_DIV   = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_FIX   = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_WRITE = PC_W'(5);

    // microprogram: a taken condition jumps to target, else next step (or wrap on last)
    function automatic ctrl_word_t seq_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        case (addr)
            STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_INPUT, target: STEP_LOAD,  last: 1'b0};
            STEP_SETUP: w = '{op: OP_SETUP, cond: COND_NEVER,    target: STEP_LOAD,  last: 1'b0};
            STEP_MUL:   w = '{op: OP_MUL,   cond: COND_SKIP,     target: STEP_WRITE, last: 1'b0};
            STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_MORE, target: STEP_DIV,   last: 1'b0};
            STEP_FIX:   w = '{op: OP_FIX,   cond: COND_NEVER,    target: STEP_LOAD,  last: 1'b0};
            STEP_WRITE: w = '{op: OP_WRITE, cond: COND_OUT_FULL, target: STEP_WRITE, last: 1'b1};
            default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_LOAD,  last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/tfcs_datapath.sv
module tfcs_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tfcs_pkg::dp_ctrl_t         ctrl,
    input  tfcs_pkg::cfg_t             cfg,
    input  logic [tfcs_pkg::TEMP_W-1:0] in_temp,
    input  logic                       in_hold,
    output tfcs_pkg::dp_stat_t         stat,
    output logic [tfcs_pkg::FREQ_W-1:0] cap_khz,
    output tfcs_pkg::region_t          region
);
    import tfcs_pkg::*;

    logic [TEMP_W-1:0]         temp_reg, temp_next;
    logic                      hold_reg, hold_next;
    region_t                   region_reg, region_next;
    logic [TEMP_W-1:0]         dt_reg, dt_next;
    logic [FREQ_W-1:0]         rmag_reg, rmag_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic                      zspan_reg, zspan_next;
    logic                      skip_reg, skip_next;
    logic signed [RANGE_W-1:0] range_reg, range_next;
    logic [PROD_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [QUO_W-1:0]   q_reg, q_next;
    logic [FREQ_W-1:0]         cap_reg, cap_next;
    region_t                   out_region_reg, out_region_next;

    logic signed [RANGE_W-1:0] range_c;
    logic signed [TEMP_W:0]    span_c;
    logic [TEMP_W-1:0]         span_mag;
    logic [TEMP_W-1:0]         dt_c;
    logic                      hot_c;
    logic                      warm_c;
    region_t                   region_c;
    logic [PROD_W-1:0]         prod_c;
    logic [REM_W-1:0]          rem_sh;
    logic                      rem_ge;
    logic                      round_up;
    logic [QUO_W-1:0]          qmag;
    logic signed [SUM_W-1:0]   cur_s, q_s, lo_s, hi_s, v_s;
    logic [FREQ_W-1:0]         cap_c;

    // operand setup
    always_comb begin
        range_c = $signed({1'b0, cfg.max_freq}) - $signed({1'b0, cfg.min_freq});
        hot_c   = temp_reg >= cfg.tolerance_temp;
        warm_c  = temp_reg >= cfg.normal_temp;
        if (hold_reg) begin
            region_c = REGION_HELD;
        end else if (hot_c) begin
            region_c = REGION_HOT;
        end else if (warm_c) begin
            region_c = REGION_WARM;
        end else begin
            region_c = REGION_COOL;
        end
        if (hot_c) begin
            span_c = $signed({1'b0, cfg.critical_temp}) - $signed({1'b0, cfg.tolerance_temp});
            dt_c   = temp_reg - cfg.tolerance_temp;
        end else begin
            span_c = $signed({1'b0, cfg.tolerance_temp}) - $signed({1'b0, cfg.normal_temp});
            dt_c   = temp_reg - cfg.normal_temp;
        end
        span_mag = span_c[TEMP_W] ? TEMP_W'(-span_c) : span_c[TEMP_W-1:0];
    end

    assign prod_c = PROD_W'(rmag_reg) * PROD_W'(dt_reg);

    // one restoring step
    assign rem_sh = {rem_reg, num_reg[PROD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    assign round_up = (region_reg == REGION_HOT) ? !neg_reg : neg_reg;
    assign qmag     = QUO_W'(num_reg) + QUO_W'(round_up && (rem_reg != '0));

    // cap update
    always_comb begin
        cur_s = $signed({{(SUM_W-FREQ_W){1'b0}}, cap_reg});
        lo_s  = $signed({{(SUM_W-FREQ_W){1'b0}}, cfg.min_freq});
        hi_s  = $signed({{(SUM_W-FREQ_W){1'b0}}, cfg.max_freq});
        q_s   = zspan_reg ? SUM_W'(range_reg) : SUM_W'(q_reg);
        case (region_reg)
            REGION_HOT: begin
                v_s = cur_s - q_s;
                if (v_s < lo_s) v_s = lo_s;
            end
            REGION_WARM: begin
                v_s = cur_s + q_s;
                if (v_s > hi_s) v_s = hi_s;
            end
            REGION_COOL: v_s = hi_s;
            default:     v_s = cur_s;
        endcase
        if (v_s < 0) begin
            cap_c = '0;
        end else if (v_s > $signed({{(SUM_W-FREQ_W){1'b0}}, {FREQ_W{1'b1}}})) begin
            cap_c = '1;
        end else begin
            cap_c = v_s[FREQ_W-1:0];
        end
    end

    always_comb begin
        temp_next       = temp_reg;
        hold_next       = hold_reg;
        region_next     = region_reg;
        dt_next         = dt_reg;
        rmag_next       = rmag_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        zspan_next      = zspan_reg;
        skip_next       = skip_reg;
        range_next      = range_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        q_next          = q_reg;
        cap_next        = cap_reg;
        out_region_next = out_region_reg;
        if (ctrl.load) begin
            temp_next = in_temp;
            hold_next = in_hold;
        end
        if (ctrl.setup) begin
            region_next = region_c;
            dt_next     = dt_c;
            rmag_next   = range_c[RANGE_W-1] ? FREQ_W'(-range_c) : range_c[FREQ_W-1:0];
            den_next    = (DEN_W'(span_mag) << 3) + (DEN_W'(span_mag) << 1);
            neg_next    = range_c[RANGE_W-1] ^ span_c[TEMP_W];
            zspan_next  = (region_c == REGION_HOT) && (span_c == '0);
            skip_next   = (region_c == REGION_HELD) || (region_c == REGION_COOL)
                          || ((region_c == REGION_HOT) && (span_c == '0));
            range_next  = range_c;
        end
        if (ctrl.mul) begin
            num_next = prod_c;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(PROD_W - 1);
        end
        if (ctrl.div) begin
            rem_next = rem_ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            num_next = {num_reg[PROD_W-2:0], rem_ge};
            cnt_next = cnt_reg - 1'b1;
        end
        if (ctrl.fix) begin
            q_next = neg_reg ? -$signed(qmag) : $signed(qmag);
        end
        if (ctrl.write) begin
            cap_next        = cap_c;
            out_region_next = region_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= MAX_FREQ_RST;
        end else begin
            cap_reg <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_reg       <= temp_next;
        hold_reg       <= hold_next;
        region_reg     <= region_next;
        dt_reg         <= dt_next;
        rmag_reg       <= rmag_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        zspan_reg      <= zspan_next;
        skip_reg       <= skip_next;
        range_reg      <= range_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        q_reg          <= q_next;
        out_region_reg <= out_region_next;
    end

    assign stat.skip     = skip_reg;
    assign stat.div_more = cnt_reg != '0;
    assign cap_khz       = cap_reg;
    assign region        = out_region_reg;

endmodule

// File: rtl/thermal_frequency_cap_stepper.sv
// Thermal frequency cap stepper. Each input beat carries the hottest zone
// temperature (millidegrees) and a hold flag; each one yields exactly one
// output beat with the updated cap in kHz and the region code. A tick that
// needs a proportional step runs load, setup, multiply, a restoring divide
// that produces one quotient bit per cycle, fix and write; held, cool and
// zero-span ticks go from multiply straight to write. The sequencer is
// back at load in the cycle after the result is written, so a new beat is
// taken only once the previous one has been written; a result still
// waiting in the output register holds the write step until it is taken.
// The result sits in an output register, so the next beat is accepted while it waits.
// Items are processed one at a time. Configuration writes are always ready.
module thermal_frequency_cap_stepper (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tfcs_pkg::S_TDATA_W-1:0]   s_tdata,  // [17:0] hottest_temp
    input  logic [0:0]                       s_tuser,  // [0] hold
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tfcs_pkg::M_TDATA_W-1:0]   m_tdata,  // [23:0] cap_khz
    output logic [1:0]                       m_tuser,  // [1:0] region
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfcs_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            m_tvalid_reg, m_tvalid_next;
    cfg_t            cfg_reg, cfg_next;

    ctrl_word_t        cw;
    logic              out_full;
    logic              cond_hit;
    logic              write_fire;
    dp_ctrl_t          dp_ctrl;
    dp_stat_t          dp_stat;
    logic [FREQ_W-1:0] cap_khz;
    region_t           region;

    assign cw         = seq_rom(pc_reg);
    assign out_full   = m_tvalid_reg && !m_tready;
    assign write_fire = (cw.op == OP_WRITE) && !out_full;
    assign s_tready   = cw.op == OP_LOAD;
    assign cfg_ready  = 1'b1;

    always_comb begin
        case (cw.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NO_INPUT: cond_hit = !s_tvalid;
            COND_SKIP:     cond_hit = dp_stat.skip;
            COND_DIV_MORE: cond_hit = dp_stat.div_more;
            COND_OUT_FULL: cond_hit = out_full;
            default:       cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            pc_next = cw.target;
        end else if (cw.last) begin
            pc_next = STEP_LOAD;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    assign dp_ctrl.load  = s_tvalid && s_tready;
    assign dp_ctrl.setup = cw.op == OP_SETUP;
    assign dp_ctrl.mul   = cw.op == OP_MUL;
    assign dp_ctrl.div   = cw.op == OP_DIV;
    assign dp_ctrl.fix   = cw.op == OP_FIX;
    assign dp_ctrl.write = write_fire;

    always_comb begin
        if (write_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MIN_FREQ:       cfg_next.min_freq       = cfg_data[FREQ_W-1:0];
                REG_MAX_FREQ:       cfg_next.max_freq       = cfg_data[FREQ_W-1:0];
                REG_NORMAL_TEMP:    cfg_next.normal_temp    = cfg_data[TEMP_W-1:0];
                REG_TOLERANCE_TEMP: cfg_next.tolerance_temp = cfg_data[TEMP_W-1:0];
                REG_CRITICAL_TEMP:  cfg_next.critical_temp  = cfg_data[TEMP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_LOAD;
            m_tvalid_reg <= 1'b0;
            cfg_reg      <= '{min_freq:       MIN_FREQ_RST,
                              max_freq:       MAX_FREQ_RST,
                              normal_temp:    NORMAL_RST,
                              tolerance_temp: TOLERANCE_RST,
                              critical_temp:  CRITICAL_RST};
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
            cfg_reg      <= cfg_next;
        end
    end

    tfcs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dp_ctrl),
        .cfg     (cfg_reg),
        .in_temp (s_tdata[TEMP_W-1:0]),
        .in_hold (s_tuser[0]),
        .stat    (dp_stat),
        .cap_khz (cap_khz),
        .region  (region)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(cap_khz);
    assign m_tuser  = region;

endmodule

// File: rtl/tfcs_checker.sv
module tfcs_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tfcs_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat in progress");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("sequencer not back at load after writing a result");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind thermal_frequency_cap_stepper tfcs_checker u_tfcs_checker (.*);

// File: bench/tb.sv
module tb;
    import tfcs_pkg::*;

    localparam int     LIMIT    = 1_000_000;
    localparam longint TEMP_TOP = (longint'(1) << TEMP_W) - 1;
    localparam longint FREQ_TOP = (longint'(1) << FREQ_W) - 1;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              hold;
    } tick_t;

    typedef struct packed {
        logic [FREQ_W-1:0] cap;
        region_t           region;
    } cap_step_t;

    typedef struct packed {
        logic [FREQ_W-1:0] min_f;
        logic [FREQ_W-1:0] max_f;
        logic [TEMP_W-1:0] nrm;
        logic [TEMP_W-1:0] tol;
        logic [TEMP_W-1:0] crit;
    } limits_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    thermal_frequency_cap_stepper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    limits_t           lim     = '{MIN_FREQ_RST, MAX_FREQ_RST, NORMAL_RST, TOLERANCE_RST,
                                   CRITICAL_RST};
    logic [FREQ_W-1:0] cap_now = MAX_FREQ_RST;

    tick_t     pending [$];
    cap_step_t cap_expected [$];

    int items_queued = 0;
    int items_taken  = 0;
    int results      = 0;
    int errors       = 0;
    int settings     = 0;
    int cycles       = 0;
    int region_seen [4] = '{0, 0, 0, 0};
    logic s_took = 1'b0;

    function automatic longint floor_div(input longint n, input longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint ceil_div(input longint n, input longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) return (n + d - 1) / d;
        return -((-n) / d);
    endfunction

    function automatic logic [FREQ_W-1:0] sat_cap(input longint v);
        if (v < 0) return '0;
        if (v > FREQ_TOP) return '1;
        return v[FREQ_W-1:0];
    endfunction

    function automatic cap_step_t next_cap(input logic [TEMP_W-1:0] temp, input logic hold);
        cap_step_t r;
        longint t, lo, hi, nrm, tol, crit, range, span, step, v;
        t     = temp;
        lo    = lim.min_f;
        hi    = lim.max_f;
        nrm   = lim.nrm;
        tol   = lim.tol;
        crit  = lim.crit;
        range = hi - lo;
        if (hold) begin
            r.cap    = cap_now;
            r.region = REGION_HELD;
        end else if (t >= tol) begin
            span = crit - tol;
            step = (span == 0) ? range : ceil_div(range * (t - tol), 10 * span);
            v    = longint'(cap_now) - step;
            if (v < lo) v = lo;
            r.cap    = sat_cap(v);
            r.region = REGION_HOT;
        end else if (t >= nrm) begin
            step = floor_div(range * (t - nrm), 10 * (tol - nrm));
            v    = longint'(cap_now) + step;
            if (v > hi) v = hi;
            r.cap    = sat_cap(v);
            r.region = REGION_WARM;
        end else begin
            r.cap    = sat_cap(hi);
            r.region = REGION_COOL;
        end
        return r;
    endfunction

    // input acceptance and result check
    always @(posedge aclk) begin
        cap_step_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results++;
                if (cap_expected.size() == 0) begin
                    $error("result beat with nothing expected: cap_khz %0d region %0d",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = cap_expected.pop_front();
                    if (m_tdata[FREQ_W-1:0] !== want.cap) begin
                        $error("cap_khz mismatch: expected %0d, got %0d", want.cap, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.region) begin
                        $error("region mismatch: expected %0d, got %0d", want.region, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want    = next_cap(s_tdata[TEMP_W-1:0], s_tuser[0]);
                cap_now = want.cap;
                cap_expected.push_back(want);
                region_seen[want.region]++;
                items_taken++;
            end
            s_took <= s_tvalid && s_tready;
        end
    end

    // sender: bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        tick_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'(nxt.temp);
                s_tuser  <= nxt.hold;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    int         rx_mode     = 0;
    int         mode_left   = 0;
    int         hold_left   = 0;
    bit         held_long   = 1'b0;
    logic [7:0] rx_phase    = '0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!held_long && items_taken >= 400) begin
                hold_left = 700;
                held_long = 1'b1;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= rx_phase[0];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MIN_FREQ:       lim.min_f = val[FREQ_W-1:0];
            REG_MAX_FREQ:       lim.max_f = val[FREQ_W-1:0];
            REG_NORMAL_TEMP:    lim.nrm   = val[TEMP_W-1:0];
            REG_TOLERANCE_TEMP: lim.tol   = val[TEMP_W-1:0];
            REG_CRITICAL_TEMP:  lim.crit  = val[TEMP_W-1:0];
            default: ;
        endcase
    endtask

    // junk fills the unused upper bits of the temperature registers
    task automatic set_limits(input limits_t l, input bit junk);
        logic [CFG_DATA_W-TEMP_W-1:0] pad [3];
        foreach (pad[i]) pad[i] = junk ? (CFG_DATA_W-TEMP_W)'($urandom) : '0;
        write_reg(REG_MIN_FREQ, l.min_f);
        write_reg(REG_MAX_FREQ, l.max_f);
        write_reg(REG_NORMAL_TEMP, {pad[0], l.nrm});
        write_reg(REG_TOLERANCE_TEMP, {pad[1], l.tol});
        write_reg(REG_CRITICAL_TEMP, {pad[2], l.crit});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic queue_tick(input longint temp, input bit hold);
        tick_t tk;
        if (temp < 0) temp = 0;
        if (temp > TEMP_TOP) temp = TEMP_TOP;
        tk.temp = temp[TEMP_W-1:0];
        tk.hold = hold;
        pending.push_back(tk);
        items_queued++;
    endtask

    task automatic threshold_ticks();
        longint marks [3];
        marks = '{longint'(lim.nrm), longint'(lim.tol), longint'(lim.crit)};
        foreach (marks[i]) begin
            queue_tick(marks[i] - 1, 1'b0);
            queue_tick(marks[i], 1'b0);
            queue_tick(marks[i] + 1, 1'b0);
        end
        queue_tick(0, 1'b0);
        queue_tick(TEMP_TOP, 1'b1);
    endtask

    task automatic random_ticks(input int n);
        int     pick;
        longint base;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       base = lim.nrm;
                1:       base = lim.tol;
                default: base = lim.crit;
            endcase
            if (pick < 12)
                queue_tick($urandom_range(0, TEMP_TOP), 1'b1);
            else if (pick < 40)
                queue_tick($urandom_range(0, TEMP_TOP), 1'b0);
            else if (pick < 88)
                queue_tick(base + longint'($urandom_range(0, 4000)) - 2000, 1'b0);
            else
                queue_tick($urandom_range(0, 1) ? TEMP_TOP - $urandom_range(0, 8)
                                                : longint'($urandom_range(0, 8)), 1'b0);
        end
    endtask

    task automatic drain();
        do @(negedge aclk); while (items_taken != items_queued || cap_expected.size() != 0);
        repeat (50) @(posedge aclk);
    endtask

    function automatic limits_t random_limits();
        limits_t           l;
        logic [TEMP_W-1:0] a, b, c, x;
        l.min_f = FREQ_W'($urandom);
        l.max_f = FREQ_W'($urandom);
        a = TEMP_W'($urandom);
        b = TEMP_W'($urandom);
        c = TEMP_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            l.min_f = FREQ_W'($urandom_range(0, 2000000));
            l.max_f = l.min_f + FREQ_W'($urandom_range(0, 4000000));
            if (a > b) begin x = a; a = b; b = x; end
            if (b > c) begin x = b; b = c; c = x; end
            if (a > b) begin x = a; a = b; b = x; end
            if ($urandom_range(0, 4) == 0) c = b;
        end
        l.nrm  = a;
        l.tol  = b;
        l.crit = c;
        return l;
    endfunction

    limits_t fixed_set [6];

    initial begin
        // full range, widest spans
        fixed_set[0] = '{24'd0, 24'hFFFFFF, 18'd0, 18'd131072, 18'h3FFFF};
        // min above max, critical below tolerance
        fixed_set[1] = '{24'hFFFFFF, 24'd0, 18'd1000, 18'd50000, 18'd40000};
        // zero lowering span
        fixed_set[2] = '{24'd100000, 24'd4000000, 18'd30000, 18'd60000, 18'd60000};
        // tolerance at zero: every tick that is not held lowers
        fixed_set[3] = '{24'd500000, 24'd2000000, 18'd0, 18'd0, 18'd255000};
        // normal above tolerance: no warm band
        fixed_set[4] = '{24'd1000000, 24'd1200000, 18'd200000, 18'd100000, 18'h3FFFF};
        // all at top
        fixed_set[5] = '{24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limits: walk the cap down to the floor and back up
        queue_tick(0, 1'b0);
        queue_tick(90000, 1'b0);
        queue_tick(TEMP_TOP, 1'b0);
        queue_tick(TEMP_TOP, 1'b0);
        queue_tick(70000, 1'b0);
        queue_tick(69999, 1'b0);
        queue_tick(50000, 1'b0);
        queue_tick(60000, 1'b0);
        queue_tick(0, 1'b1);
        queue_tick(TEMP_TOP, 1'b1);
        queue_tick(49999, 1'b0);
        queue_tick(60000, 1'b0);
        queue_tick(255000, 1'b0);
        queue_tick(89999, 1'b0);
        queue_tick(70001, 1'b0);
        queue_tick(131072, 1'b0);
        random_ticks(60);
        drain();

        foreach (fixed_set[i]) begin
            set_limits(fixed_set[i], 1'b0);
            threshold_ticks();
            random_ticks(90);
            drain();
        end

        repeat (3) begin
            set_limits(random_limits(), 1'b1);
            threshold_ticks();
            random_ticks(90);
            drain();
        end

        repeat (60) @(posedge aclk);
        $display("%0d ticks checked over %0d register settings, %0d results seen",
                 items_taken, settings + 1, results);
        $display("regions: cool %0d, warm %0d, hot %0d, held %0d",
                 region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
        if (errors == 0 && cap_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: thermal_frequency_cap_stepper.f
rtl/tfcs_pkg.sv
rtl/tfcs_datapath.sv
rtl/thermal_frequency_cap_stepper.sv
rtl/tfcs_checker.sv
bench/tb.sv
